// ===== hw/rtl/ssra_pkg.sv =====
// Shared types and codes for the swap slot run allocator.
package ssra_pkg;

  localparam int WORD_BITS = 64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [9:0] slot_start;
  } req_t;

  typedef struct packed {
    logic [9:0] run_start;
    logic [1:0] status;
  } rsp_t;

  // Outcome of evaluating one bitmap word during a search.
  typedef struct packed {
    logic       hit;
    logic [5:0] hit_pos;
    logic [5:0] carry;
  } scan_res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MOD_RD,
    S_MOD_WA,
    S_MOD_WB
  } ctl_state_t;

endpackage

// ===== hw/rtl/ssra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ssra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ssra_scan.sv =====
// Evaluates one bitmap word of a first-fit run search with a carried run count.
module ssra_scan
  import ssra_pkg::*;
#(
  parameter int RUN_LENGTH = 8
) (
  input  logic [WORD_BITS-1:0] free_word,
  input  logic [5:0]           carry,
  output scan_res_t            res
);

  // Free bits below the word come from the carried count of the previous word.
  logic [WORD_BITS+RUN_LENGTH-1:0] ext;
  logic [WORD_BITS-1:0]            hitv;

  always_comb begin
    for (int k = 0; k < RUN_LENGTH; k++) begin
      ext[k] = (k + int'(carry)) >= RUN_LENGTH;
    end
    ext[WORD_BITS+RUN_LENGTH-1:RUN_LENGTH] = free_word;

    for (int j = 0; j < WORD_BITS; j++) begin
      hitv[j] = &ext[j+1 +: RUN_LENGTH];
    end
  end

  always_comb begin
    res.hit     = |hitv;
    res.hit_pos = '0;
    res.carry   = '0;
    // Lowest ending position wins.
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hitv[j]) begin
        res.hit_pos = 6'(j);
      end
    end
    // Run of free bits at the top of the word; the highest used bit sets it.
    for (int k = 0; k < RUN_LENGTH; k++) begin
      if (!ext[WORD_BITS+k]) begin
        res.carry = 6'(RUN_LENGTH - 1 - k);
      end
    end
  end

endmodule

// ===== hw/rtl/swap_slot_run_allocator.sv =====
// First-fit allocator of sector runs over a sector usage bitmap held in RAM.
// Allocate: searches one 64-bit bitmap word per cycle, then read-modify-writes the word holding
// the run (and the next word if the run crosses into it) and responds. Free: the same
// read-modify-write. A free past the end is answered without leaving idle, a full bitmap once
// the last word is searched. One request at a time. After reset a clearing pass writes every
// bitmap word with busy high. The result strobe lasts one cycle; the receiver cannot stall it.
module swap_slot_run_allocator
  import ssra_pkg::*;
#(
  parameter int SECTORS    = 1024,
  parameter int RUN_LENGTH = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output rsp_t out_rsp
);

  localparam int WB        = WORD_BITS;
  localparam int NW        = (SECTORS + WB - 1) / WB;
  localparam int AW        = (NW > 1) ? $clog2(NW) : 1;
  localparam int PW        = AW + 6;
  localparam int XW        = ((PW > 10) ? PW : 10) + 1;
  localparam int LAST_BITS = SECTORS - WB * (NW - 1);

  localparam logic [AW-1:0]   LAST_W    = AW'(NW - 1);
  localparam logic [WB-1:0]   LAST_MASK = ~({WB{1'b1}} << LAST_BITS);
  localparam logic [2*WB-1:0] RUN_ONES  = ~({(2*WB){1'b1}} << RUN_LENGTH);

  ctl_state_t     state_r, state_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic [5:0]     carry_r, carry_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic           set_r, set_nxt;
  logic           out_valid_r, out_valid_nxt;
  rsp_t           out_rsp_r, out_rsp_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [WB-1:0]  ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [WB-1:0]  ram_rdata;

  logic [WB-1:0]   free_word;
  scan_res_t       sres;
  logic [XW-1:0]   req_start;
  logic [2*WB-1:0] run_mask;
  logic [AW-1:0]   word_a;
  logic [XW-1:0]   pos_ext;

  ssra_ram #(
    .WIDTH(WB),
    .DEPTH(NW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Padding bits past the last sector never count as free.
  assign free_word = ~ram_rdata & ((ptr_r == LAST_W) ? LAST_MASK : {WB{1'b1}});

  ssra_scan #(
    .RUN_LENGTH(RUN_LENGTH)
  ) u_scan (
    .free_word (free_word),
    .carry     (carry_r),
    .res       (sres)
  );

  assign req_start = XW'(in_req.slot_start);
  assign run_mask  = RUN_ONES << pos_r[5:0];
  assign word_a    = pos_r[PW-1:6];
  assign pos_ext   = XW'(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r   <= carry_nxt;
    pos_r     <= pos_nxt;
    set_r     <= set_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    carry_nxt     = carry_r;
    pos_nxt       = pos_r;
    set_nxt       = set_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    ram_we        = 1'b0;
    ram_waddr     = word_a;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        if (ptr_r == LAST_W) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          if (in_req.opcode == OP_ALLOC) begin
            ptr_nxt   = '0;
            carry_nxt = '0;
            set_nxt   = 1'b1;
            state_nxt = S_SCAN;
          end else if (req_start + XW'(RUN_LENGTH) > XW'(SECTORS)) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{run_start: '0, status: STAT_RANGE};
          end else begin
            pos_nxt   = req_start[PW-1:0];
            set_nxt   = 1'b0;
            state_nxt = S_MOD_RD;
          end
        end
      end

      S_SCAN: begin
        // Fetch the next word while this one is evaluated.
        ram_raddr = (ptr_r == LAST_W) ? ptr_r : ptr_r + 1'b1;
        if (sres.hit) begin
          pos_nxt   = {ptr_r, 6'd0} + PW'(sres.hit_pos) + PW'(1) - PW'(RUN_LENGTH);
          state_nxt = S_MOD_RD;
        end else if (ptr_r == LAST_W) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{run_start: '0, status: STAT_FULL};
          state_nxt     = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          carry_nxt = sres.carry;
        end
      end

      S_MOD_RD: begin
        ram_raddr = word_a;
        state_nxt = S_MOD_WA;
      end

      S_MOD_WA: begin
        ram_we    = 1'b1;
        ram_waddr = word_a;
        ram_wdata = set_r ? (ram_rdata | run_mask[WB-1:0])
                          : (ram_rdata & ~run_mask[WB-1:0]);
        if (|run_mask[2*WB-1:WB]) begin
          // Run crosses into the next word.
          ram_raddr = word_a + 1'b1;
          state_nxt = S_MOD_WB;
        end else begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{run_start: set_r ? pos_ext[9:0] : 10'd0, status: STAT_OK};
          state_nxt     = S_IDLE;
        end
      end

      S_MOD_WB: begin
        ram_we        = 1'b1;
        ram_waddr     = word_a + 1'b1;
        ram_wdata     = set_r ? (ram_rdata | run_mask[2*WB-1:WB])
                              : (ram_rdata & ~run_mask[2*WB-1:WB]);
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{run_start: set_r ? pos_ext[9:0] : 10'd0, status: STAT_OK};
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== sim/tb_swap_slot_run_allocator.sv =====
// Self-checking testbench for the swap slot run allocator: directed and random requests.
module tb_swap_slot_run_allocator;
  import ssra_pkg::*;

  localparam int SECTORS     = 1024;
  localparam int RUN_LENGTH  = 8;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 10;

  // Bitmap shadow plus the responses it predicts, oldest first.
  class run_bitmap_scoreboard;
    logic [SECTORS-1:0] sector_map;
    rsp_t               pending_rsp[$];
    logic [9:0]         live_runs[$];
    int                 errors;

    function new();
      sector_map = '0;
      errors     = 0;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endfunction

    // Predict the response of an accepted transaction and update the shadow map.
    function void note_request(req_t req);
      rsp_t exp_rsp;
      int   run;
      int   base;
      bit   found;
      exp_rsp.run_start = '0;
      exp_rsp.status    = STAT_OK;
      if (req.opcode == OP_ALLOC) begin
        run   = 0;
        base  = 0;
        found = 1'b0;
        for (int i = 0; i < SECTORS && !found; i++) begin
          if (sector_map[i]) begin
            run = 0;
          end else begin
            run++;
            if (run >= RUN_LENGTH) begin
              found = 1'b1;
              base  = i + 1 - RUN_LENGTH;
            end
          end
        end
        if (found) begin
          for (int i = 0; i < RUN_LENGTH; i++) sector_map[base + i] = 1'b1;
          exp_rsp.run_start = base[9:0];
          live_runs.push_back(base[9:0]);
        end else begin
          exp_rsp.status = STAT_FULL;
        end
      end else begin
        if (int'(req.slot_start) + RUN_LENGTH > SECTORS) begin
          exp_rsp.status = STAT_RANGE;
        end else begin
          for (int i = 0; i < RUN_LENGTH; i++) sector_map[int'(req.slot_start) + i] = 1'b0;
        end
      end
      pending_rsp.push_back(exp_rsp);
    endfunction

    function void check_response(rsp_t act);
      rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        report($sformatf("response with nothing pending: run_start=%0d status=%0d",
                         act.run_start, act.status));
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (act.run_start !== exp_rsp.run_start)
        report($sformatf("run_start expected %0d actual %0d", exp_rsp.run_start,
                         act.run_start));
      if (act.status !== exp_rsp.status)
        report($sformatf("status expected %0d actual %0d", exp_rsp.status, act.status));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  rsp_t out_rsp;

  int                   idle_cycles;
  run_bitmap_scoreboard sb;

  swap_slot_run_allocator #(
    .SECTORS    (SECTORS),
    .RUN_LENGTH (RUN_LENGTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_response(out_rsp);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap(bit allow);
    int roll;
    if (!allow) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Present one transaction, hold it until accepted, then let start drop for the given gap.
  task automatic send(input logic op, input logic [9:0] slot, input int gap);
    @(negedge clk);
    in_req.opcode     = op;
    in_req.slot_start = slot;
    start             = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(in_req);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off the sender until every predicted response has come back.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int alloc_pct, input bit gaps);
    logic       op;
    logic [9:0] slot;
    int         roll;
    int         idx;
    for (int n = 0; n < count; n++) begin
      slot = 10'($urandom_range(1023));
      if ($urandom_range(99) < alloc_pct) begin
        op = OP_ALLOC;
      end else begin
        op   = OP_FREE;
        roll = $urandom_range(99);
        if (roll < 55 && sb.live_runs.size() > 0) begin
          idx  = $urandom_range(sb.live_runs.size() - 1);
          slot = sb.live_runs[idx];
          sb.live_runs.delete(idx);
        end else if (roll < 75) begin
          // aim at the top of the map, where frees may run past the end
          slot = 10'($urandom_range(1023, 1000));
        end
      end
      send(op, slot, pick_gap(gaps));
    end
  endtask

  initial begin
    sb          = new();
    idle_cycles = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(OP_ALLOC, 10'h3FF, 0);
    send(OP_ALLOC, 10'h000, 1);
    send(OP_ALLOC, 10'h155, 0);
    // open a hole in the middle, then refill it first-fit
    send(OP_FREE,  10'd8,    2);
    send(OP_ALLOC, 10'h2AA, 0);
    // unaligned free straddling two runs
    send(OP_FREE,  10'd3,    0);
    send(OP_ALLOC, 10'h000, 3);
    // last legal start, already clear
    send(OP_FREE,  10'd1016, 0);
    send(OP_FREE,  10'd1017, 1);
    send(OP_FREE,  10'd1023, 0);
    send(OP_FREE,  10'd0,    0);
    send(OP_FREE,  10'd0,    2);
    send(OP_ALLOC, 10'h000, 0);
    send(OP_ALLOC, 10'h3FF, 0);
    send(OP_FREE,  10'd1008, 1);
    drain();

    // alloc-heavy: fill the map and hit the full case
    run_phase(200, 85, 1'b1);
    drain();
    run_phase(100, 50, 1'b0);
    run_phase(100, 50, 1'b1);
    drain();
    run_phase(150, 30, 1'b1);
    drain();

    repeat (40) @(posedge clk);
    if (sb.pending() > 0)
      $display("%0d predicted responses never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
